// File: design/usb_config_descriptor_validator_defines.svh
// ----------------------------------------------------------------------------
// USB configuration descriptor validator - assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef USB_CONFIG_DESCRIPTOR_VALIDATOR_DEFINES_SVH
`define USB_CONFIG_DESCRIPTOR_VALIDATOR_DEFINES_SVH

// Check sampled on every rising edge, also while reset is held
`define CDV_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

// Check sampled on rising edges, switched off while dis is high
`define CDV_ASSERT_IFF(label, clk, dis, prop, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (prop)) else $error(msg);

`endif

// File: design/usbcdv_pkg.sv
// ----------------------------------------------------------------------------
// USB configuration descriptor validator - package
// Shared types and descriptor constants.
// ----------------------------------------------------------------------------
package usbcdv_pkg;

    // Descriptor sizes and limits
    localparam logic [7:0] HEADER_SIZE   = 8'd9;
    localparam logic [7:0] INTERFACE_MIN = 8'd9;
    localparam logic [7:0] ENDPOINT_MIN  = 8'd7;
    localparam logic [7:0] ENTRY_MIN     = 8'd2;
    localparam logic [8:0] COUNT_MAX     = 9'h1FF;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    // Descriptor type codes
    localparam logic [7:0] TYPE_CONFIGURATION = 8'd2;
    localparam logic [7:0] TYPE_INTERFACE     = 8'd4;
    localparam logic [7:0] TYPE_ENDPOINT      = 8'd5;

    // Header byte offsets
    localparam logic [3:0] HDR_LENGTH       = 4'd0;
    localparam logic [3:0] HDR_TYPE         = 4'd1;
    localparam logic [3:0] HDR_TOTAL_LO     = 4'd2;
    localparam logic [3:0] HDR_TOTAL_HI     = 4'd3;
    localparam logic [3:0] HDR_NUM_IFACES   = 4'd4;
    localparam logic [3:0] HDR_CONFIG_VALUE = 4'd5;

    // Sub-descriptor byte offsets
    localparam logic [7:0] ENT_LENGTH    = 8'd0;
    localparam logic [7:0] ENT_TYPE      = 8'd1;
    localparam logic [7:0] ENT_IFACE_NUM = 8'd2;
    localparam logic [7:0] ENT_ALT       = 8'd3;
    localparam logic [7:0] ENT_NUM_EP    = 8'd4;

    // One registered input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    // One descriptor verdict
    typedef struct packed {
        logic [7:0]  configuration_value;
        logic [15:0] declared_length;
        logic [8:0]  interface_count;
        logic        is_valid;
    } result_t;

endpackage

// File: design/usbcdv_in_stage.sv
// ----------------------------------------------------------------------------
// USB configuration descriptor validator - input register
// Holds one accepted byte and hands it to the checker when it can advance.
// ----------------------------------------------------------------------------
module usbcdv_in_stage (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] data_byte
    input  logic                    s_tlast,
    input  logic                    out_free,
    output logic                    step,
    output usbcdv_pkg::byte_item_t  item
);
    import usbcdv_pkg::*;

    logic       valid_reg;
    byte_item_t item_reg;

    // A last byte needs room in the result register, others always advance
    assign step     = valid_reg && (!item_reg.last_byte || out_free);
    assign s_tready = !valid_reg || step;
    assign item     = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.data_byte <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

endmodule

// File: design/usbcdv_check.sv
// ----------------------------------------------------------------------------
// USB configuration descriptor validator - descriptor walker
// Header decode, sub-descriptor walk, interface map and verdict, one byte
// per step.
// ----------------------------------------------------------------------------
`include "usb_config_descriptor_validator_defines.svh"

module usbcdv_check #(
    parameter int unsigned INTERFACE_SLOTS = 256
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  usbcdv_pkg::byte_item_t  item,
    output logic                    res_valid,
    output usbcdv_pkg::result_t     res
);
    import usbcdv_pkg::*;

    localparam int unsigned SLOT_W = $clog2(INTERFACE_SLOTS);

    // Walk state
    logic [15:0] pos_reg, pos_next;
    logic [15:0] total_reg, total_next;
    logic [7:0]  exp_ifs_reg, exp_ifs_next;
    logic [7:0]  cfg_num_reg, cfg_num_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  size_reg, size_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  num_reg, num_next;
    logic [7:0]  alt_reg, alt_next;
    logic        inside_reg, inside_next;
    logic [8:0]  eps_reg, eps_next;
    logic [7:0]  ep_exp_reg, ep_exp_next;
    logic [8:0]  ifs_reg, ifs_next;
    logic        ok_reg, ok_next;
    logic [INTERFACE_SLOTS-1:0] map_reg, map_next;

    // Interface number to map slot, worked out at elaboration
    logic [SLOT_W-1:0] slot_tbl [256];

    for (genvar g = 0; g < 256; g++) begin : g_slot
        localparam int unsigned SLOT = g % INTERFACE_SLOTS;
        assign slot_tbl[g] = SLOT_W'(SLOT);
    end

    logic [7:0]  b;
    logic        restart;

    assign b       = item.data_byte;
    assign restart = step && item.last_byte;

    // Next state for one byte
    always_comb begin
        logic              hold;
        logic [7:0]        idx_inc;
        logic [15:0]       remaining;
        logic [SLOT_W-1:0] slot;
        logic [16:0]       received;

        hold      = 1'b0;
        idx_inc   = '0;
        remaining = '0;
        slot      = '0;

        total_next   = total_reg;
        exp_ifs_next = exp_ifs_reg;
        cfg_num_next = cfg_num_reg;
        idx_next     = idx_reg;
        size_next    = size_reg;
        kind_next    = kind_reg;
        num_next     = num_reg;
        alt_next     = alt_reg;
        inside_next  = inside_reg;
        eps_next     = eps_reg;
        ep_exp_next  = ep_exp_reg;
        ifs_next     = ifs_reg;
        ok_next      = ok_reg;
        map_next     = map_reg;

        if (ok_reg) begin
            if (pos_reg < {8'd0, HEADER_SIZE}) begin
                // Configuration header
                unique case (pos_reg[3:0])
                    HDR_LENGTH: begin
                        if (b != HEADER_SIZE) ok_next = 1'b0;
                    end
                    HDR_TYPE: begin
                        if (b != TYPE_CONFIGURATION) ok_next = 1'b0;
                    end
                    HDR_TOTAL_LO: begin
                        total_next = {total_reg[15:8], b};
                    end
                    HDR_TOTAL_HI: begin
                        total_next = {b, total_reg[7:0]};
                        if ({b, total_reg[7:0]} < {8'd0, HEADER_SIZE}) ok_next = 1'b0;
                    end
                    HDR_NUM_IFACES: begin
                        exp_ifs_next = b;
                    end
                    HDR_CONFIG_VALUE: begin
                        cfg_num_next = b;
                        if (b == 8'd0) ok_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end else if (pos_reg >= total_reg) begin
                // Byte beyond the declared total
                ok_next = 1'b0;
            end else begin
                // Sub-descriptor walk
                if (idx_reg == ENT_LENGTH) begin
                    remaining = total_reg - pos_reg;
                    if (b < ENTRY_MIN || {8'd0, b} > remaining) begin
                        ok_next = 1'b0;
                        hold    = 1'b1;
                    end else begin
                        size_next = b;
                    end
                end else if (idx_reg == ENT_TYPE) begin
                    kind_next = b;
                    if (b == TYPE_INTERFACE) begin
                        if (size_reg < INTERFACE_MIN ||
                            (inside_reg && eps_reg != {1'b0, ep_exp_reg})) begin
                            ok_next = 1'b0;
                            hold    = 1'b1;
                        end
                    end else if (b == TYPE_ENDPOINT) begin
                        eps_next = (eps_reg < COUNT_MAX) ? eps_reg + 9'd1 : eps_reg;
                        if (size_reg < ENDPOINT_MIN || !inside_reg ||
                            eps_next > {1'b0, ep_exp_reg}) begin
                            ok_next = 1'b0;
                            hold    = 1'b1;
                        end
                    end
                end else if (kind_reg == TYPE_INTERFACE) begin
                    if (idx_reg == ENT_IFACE_NUM) begin
                        num_next = b;
                    end else if (idx_reg == ENT_ALT) begin
                        alt_next = b;
                    end else if (idx_reg == ENT_NUM_EP) begin
                        inside_next = 1'b1;
                        eps_next    = '0;
                        ep_exp_next = b;
                        // Alternate zero opens a new interface number
                        if (alt_reg == 8'd0) begin
                            slot = slot_tbl[num_reg];
                            if (map_reg[slot]) ok_next = 1'b0;
                            map_next[slot] = 1'b1;
                            if (ok_next && ifs_reg < COUNT_MAX) ifs_next = ifs_reg + 9'd1;
                            if (!ok_next) hold = 1'b1;
                        end
                    end
                end

                if (!hold) begin
                    idx_inc  = idx_reg + 8'd1;
                    idx_next = (idx_inc >= size_next) ? 8'd0 : idx_inc;
                end
            end
        end

        // Byte count runs on after a failure and saturates
        pos_next = (pos_reg != POS_MAX) ? pos_reg + 16'd1 : pos_reg;

        // Verdict on the last byte
        received                = {1'b0, pos_reg} + 17'd1;
        res.is_valid            = ok_next && (received == {1'b0, total_next}) &&
                                  (ifs_next == {1'b0, exp_ifs_next}) &&
                                  (eps_next == {1'b0, ep_exp_next});
        res.interface_count     = ifs_next;
        res.declared_length     = total_next;
        res.configuration_value = cfg_num_next;
    end

    assign res_valid = restart;

    // State update, back to the start after each descriptor
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            pos_reg     <= '0;
            total_reg   <= '0;
            exp_ifs_reg <= '0;
            cfg_num_reg <= '0;
            idx_reg     <= '0;
            size_reg    <= '0;
            kind_reg    <= '0;
            num_reg     <= '0;
            alt_reg     <= '0;
            inside_reg  <= 1'b0;
            eps_reg     <= '0;
            ep_exp_reg  <= '0;
            ifs_reg     <= '0;
            ok_reg      <= 1'b1;
            map_reg     <= '0;
        end else if (step) begin
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            exp_ifs_reg <= exp_ifs_next;
            cfg_num_reg <= cfg_num_next;
            idx_reg     <= idx_next;
            size_reg    <= size_next;
            kind_reg    <= kind_next;
            num_reg     <= num_next;
            alt_reg     <= alt_next;
            inside_reg  <= inside_next;
            eps_reg     <= eps_next;
            ep_exp_reg  <= ep_exp_next;
            ifs_reg     <= ifs_next;
            ok_reg      <= ok_next;
            map_reg     <= map_next;
        end
    end

    // Checks
    `CDV_ASSERT(a_reset_restarts, aclk, !aresetn |=> (pos_reg == 16'd0 && ok_reg), "reset did not restart the walk")
    `CDV_ASSERT_IFF(a_last_clears, aclk, !aresetn, restart |=> (pos_reg == 16'd0 && ok_reg && map_reg == '0), "walk state not cleared after last byte")
    `CDV_ASSERT_IFF(a_fail_sticks, aclk, !aresetn, (!ok_reg && !restart) |=> !ok_reg, "failure cleared inside a descriptor")
    `CDV_ASSERT_IFF(a_idle_holds, aclk, !aresetn, !step |=> $stable(pos_reg) && $stable(ifs_reg), "walk state moved without a byte")

endmodule

// File: design/usbcdv_out_stage.sv
// ----------------------------------------------------------------------------
// USB configuration descriptor validator - result register
// Holds one verdict word until the downstream side takes it.
// ----------------------------------------------------------------------------
module usbcdv_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 res_valid,
    input  usbcdv_pkg::result_t  res,
    output logic                 out_free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata    // [0] is_valid, [9:1] interface_count,
                                            // [25:10] declared_length,
                                            // [33:26] configuration_value, [39:34] zero
);
    import usbcdv_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.configuration_value, res_reg.declared_length,
                       res_reg.interface_count, res_reg.is_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

// File: design/usb_config_descriptor_validator.sv
// ----------------------------------------------------------------------------
// USB configuration descriptor validator - top level
// Checks the structure of a configuration descriptor streamed in byte by byte.
// ----------------------------------------------------------------------------
// The block takes one descriptor byte per clock, with tlast on the final byte,
// and returns one verdict word for each descriptor: pass flag, alternate-zero
// interface count, declared total length and configuration value. Each byte
// goes through an input register and one pass of the descriptor walker, and
// the verdict is written into the result register as the last byte leaves
// the input register. Bytes keep flowing while a verdict waits to be
// taken; only the next last byte waits until the result register is free. The
// walk state and the interface seen map (INTERFACE_SLOTS flops) are cleared in
// the same cycle the last byte is processed, so the next descriptor may follow
// at once.
module usb_config_descriptor_validator #(
    parameter int unsigned INTERFACE_SLOTS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [0] is_valid, [9:1] interface_count,
                                    // [25:10] declared_length,
                                    // [33:26] configuration_value, [39:34] zero
);
    import usbcdv_pkg::*;

    logic       step;
    logic       out_free;
    logic       res_valid;
    byte_item_t item;
    result_t    res;

    usbcdv_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .out_free (out_free),
        .step     (step),
        .item     (item)
    );

    usbcdv_check #(
        .INTERFACE_SLOTS (INTERFACE_SLOTS)
    ) u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    usbcdv_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
